// ----- sv/fpr_pkg.sv -----
// Shared types and constants for the fan PWM ramp controller.
package fpr_pkg;

  localparam int unsigned PCT_W   = 7;
  localparam int unsigned SEL_W   = 2;
  localparam int unsigned ACC_W   = 15;
  localparam int unsigned STEP_W  = 15;
  localparam int unsigned WAIT_W  = 16;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [PCT_W-1:0] FULL_PCT = 7'd100;
  localparam logic [ACC_W-1:0] FULL_Q   = 15'd25600;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_UP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DOWN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPINDOWN  = 3'd4;

  // Configuration reset values
  localparam logic [PCT_W-1:0]  RST_MIN_START = 7'd30;
  localparam logic [PCT_W-1:0]  RST_IDLE      = 7'd20;
  localparam logic [STEP_W-1:0] RST_RAMP_UP   = 15'd256;
  localparam logic [STEP_W-1:0] RST_RAMP_DOWN = 15'd256;
  localparam logic [WAIT_W-1:0] RST_SPINDOWN  = 16'd100;

  typedef enum logic [2:0] {
    MODE_SPINDOWN = 3'b001,
    MODE_RAMPING  = 3'b010,
    MODE_MINSTART = 3'b100
  } mode_e;

  typedef struct packed {
    logic [SEL_W-1:0] motor_sel;
    logic [PCT_W-1:0] request_pct;
  } in_item_t;

  typedef struct packed {
    logic [SEL_W-1:0] motor_out;
    logic [PCT_W-1:0] duty_pct;
  } out_item_t;

  typedef struct packed {
    logic [PCT_W-1:0]  min_start_pct;
    logic [PCT_W-1:0]  idle_pct;
    logic [STEP_W-1:0] ramp_up_step;
    logic [STEP_W-1:0] ramp_down_step;
    logic [WAIT_W-1:0] spindown_ticks;
  } cfg_t;

  typedef struct packed {
    mode_e             mode;
    logic [WAIT_W-1:0] wait_count;
    logic [PCT_W-1:0]  goal_pct;
    logic [ACC_W-1:0]  accum_q;
    logic [PCT_W-1:0]  last_duty;
  } mot_state_t;

  typedef struct packed {
    logic             emit;
    logic [PCT_W-1:0] duty;
  } step_res_t;

endpackage

// ----- sv/fpr_step.sv -----
// Next-state and duty update for one motor on one tick.
module fpr_step (
  input  fpr_pkg::mot_state_t       state_i,
  input  fpr_pkg::cfg_t             cfg_i,
  input  logic [fpr_pkg::PCT_W-1:0] request_pct_i,
  output fpr_pkg::mot_state_t       state_o,
  output fpr_pkg::step_res_t        res_o
);
  import fpr_pkg::*;

  always_comb begin
    mot_state_t        ns;
    step_res_t         res;
    logic [PCT_W-1:0]  req;
    logic [PCT_W-1:0]  mstart;
    logic [WAIT_W-1:0] wc;
    logic              go;
    logic              do_ramp;
    logic [ACC_W-1:0]  tq;
    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  acc_n;
    logic [PCT_W-1:0]  whole;

    ns      = state_i;
    res     = '0;
    go      = 1'b1;
    do_ramp = 1'b0;
    wc      = state_i.wait_count;
    req     = (request_pct_i > FULL_PCT) ? FULL_PCT : request_pct_i;
    mstart  = (cfg_i.min_start_pct > FULL_PCT) ? FULL_PCT : cfg_i.min_start_pct;

    if (state_i.mode == MODE_MINSTART) begin
      // Kick level reached: take the request as the new target next
      if (state_i.accum_q == {state_i.goal_pct, {FRAC_W{1'b0}}}) begin
        ns.goal_pct = req;
        ns.mode     = MODE_RAMPING;
      end else begin
        do_ramp = 1'b1;
      end
    end else begin
      if (state_i.mode != MODE_RAMPING) begin
        if (wc != '0) begin
          wc = wc - 1'b1;
        end
        ns.wait_count = wc;
        if (wc != '0) begin
          go = 1'b0;
        end else begin
          ns.mode = MODE_RAMPING;
        end
      end
      if (go) begin
        if (req == '0) begin
          if (state_i.goal_pct != '0 || state_i.accum_q != '0) begin
            ns.wait_count = cfg_i.spindown_ticks;
            ns.accum_q    = '0;
            ns.goal_pct   = '0;
            ns.last_duty  = '0;
            ns.mode       = MODE_SPINDOWN;
            res.emit      = 1'b1;
            res.duty      = '0;
          end
        end else if (req < mstart && state_i.goal_pct < cfg_i.idle_pct) begin
          ns.goal_pct = mstart;
          ns.mode     = MODE_MINSTART;
          do_ramp     = 1'b1;
        end else begin
          ns.goal_pct = req;
          do_ramp     = 1'b1;
        end
      end
    end

    // Step toward the target, landing exactly on it
    tq  = {ns.goal_pct, {FRAC_W{1'b0}}};
    acc = ns.accum_q;
    if (acc < tq) begin
      acc_n = ((tq - acc) <= cfg_i.ramp_up_step) ? tq : acc + cfg_i.ramp_up_step;
    end else begin
      acc_n = ((acc - tq) <= cfg_i.ramp_down_step) ? tq : acc - cfg_i.ramp_down_step;
    end
    whole = acc_n[ACC_W-1:FRAC_W];

    if (do_ramp && acc != tq) begin
      ns.accum_q = acc_n;
      if (whole != ns.last_duty) begin
        ns.last_duty = whole;
        res.emit     = 1'b1;
        res.duty     = whole;
      end
    end

    state_o = ns;
    res_o   = res;
  end

endmodule

// ----- sv/fan_pwm_ramp_controller.sv -----
// Top level of the fan PWM soft-start ramp controller.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | input     | in_valid_i/in_stall_o | in_i   {motor_sel, request_pct}
//  out     | output    | out_valid_o/out_stall_i | out_o {motor_out, duty_pct}
//  cfg     | input     | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// One tick request per cycle sustained unless stalled. A transfer lands
// in the stage register, is evaluated against its motor's state in the
// next cycle and its result, if any, enters the output register as the
// stage advances. Per-motor state is written back at evaluation, so
// back-to-back ticks on the same motor see each other's updates. A stalled
// output blocks the stage only when the staged tick produces a result. Reset
// restores the configuration defaults and puts every motor into spin-down.
module fan_pwm_ramp_controller #(
  parameter int unsigned NUM_MOTORS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  fpr_pkg::in_item_t             in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output fpr_pkg::out_item_t            out_o,
  input  logic                          cfg_we_i,
  input  logic [fpr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fpr_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import fpr_pkg::*;

  localparam int unsigned IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int unsigned CMP_W = 5;

  // Configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_start_pct  <= RST_MIN_START;
      cfg_q.idle_pct       <= RST_IDLE;
      cfg_q.ramp_up_step   <= RST_RAMP_UP;
      cfg_q.ramp_down_step <= RST_RAMP_DOWN;
      cfg_q.spindown_ticks <= RST_SPINDOWN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_START: cfg_q.min_start_pct  <= cfg_wdata_i[PCT_W-1:0];
        CFG_IDLE:      cfg_q.idle_pct       <= cfg_wdata_i[PCT_W-1:0];
        CFG_RAMP_UP:   cfg_q.ramp_up_step   <= cfg_wdata_i[STEP_W-1:0];
        CFG_RAMP_DOWN: cfg_q.ramp_down_step <= cfg_wdata_i[STEP_W-1:0];
        CFG_SPINDOWN:  cfg_q.spindown_ticks <= cfg_wdata_i[WAIT_W-1:0];
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  // Stage register holding the accepted tick
  in_item_t stage_q;
  logic     stage_valid_q;

  // Output register
  out_item_t out_q;
  logic      out_valid_q;

  // Per-motor state
  mot_state_t mot_q [NUM_MOTORS];

  logic [CMP_W-1:0] sel_ext;
  logic [IDX_W-1:0] sel_idx;
  logic             sel_ok;
  mot_state_t       cur_state;
  mot_state_t       nxt_state;
  step_res_t        step_res;
  logic             out_free;
  logic             advance;
  logic             in_take;

  assign sel_ext   = CMP_W'(stage_q.motor_sel);
  assign sel_idx   = sel_ext[IDX_W-1:0];
  assign sel_ok    = (sel_ext < CMP_W'(NUM_MOTORS));
  assign cur_state = mot_q[sel_idx];

  fpr_step u_step (
    .state_i       (cur_state),
    .cfg_i         (cfg_q),
    .request_pct_i (stage_q.request_pct),
    .state_o       (nxt_state),
    .res_o         (step_res)
  );

  // Advance the stage unless its result has nowhere to go
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = stage_valid_q && (!(sel_ok && step_res.emit) || out_free);
  assign in_stall_o = stage_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_take) begin
      stage_valid_q <= 1'b1;
    end else if (advance) begin
      stage_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      stage_q <= in_i;
    end
  end

  // Write back the motor state; ignore ticks for absent motors
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        mot_q[i].mode       <= MODE_SPINDOWN;
        mot_q[i].wait_count <= RST_SPINDOWN;
        mot_q[i].goal_pct   <= '0;
        mot_q[i].accum_q    <= '0;
        mot_q[i].last_duty  <= '0;
      end
    end else if (advance && sel_ok) begin
      mot_q[sel_idx] <= nxt_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && sel_ok && step_res.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_free) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && sel_ok && step_res.emit) begin
      out_q.motor_out <= stage_q.motor_sel;
      out_q.duty_pct  <= step_res.duty;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Emitted duty never exceeds full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.duty_pct <= FULL_PCT)
    else $error("duty above full scale");

  // Accumulator of the first motor stays within full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mot_q[0].accum_q <= FULL_Q)
    else $error("accumulator above full scale");

  // Input is held back only while a staged tick waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> stage_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked result");

  // A held stage keeps the first motor's state untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(mot_q[0]))
    else $error("motor state changed while stage held");

endmodule

// ----- dv/fan_pwm_ramp_controller_tb.sv -----
// Self-checking testbench for the fan PWM soft-start ramp controller.
`timescale 1ns / 100ps

module fan_pwm_ramp_controller_tb;
  import fpr_pkg::*;

  localparam int unsigned NUM_MOT     = 4;
  localparam int unsigned CYCLE_LIMIT = 900_000;
  // Pad a little after the last owed update before touching registers.
  localparam int unsigned SETTLE_CYC  = 6;
  localparam int unsigned PRINT_CAP   = 30;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_TICKS = 80;
  localparam int unsigned LONG_SPIN   = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = CFG_SPINDOWN + 3'd1;

  // Clock, reset and block ports.
  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  in_item_t   in_i;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // Shadow of the register file and of every motor's ramp state.
  cfg_t       fan_cfg;
  mot_state_t motor_st [NUM_MOT];

  // Duty updates the block still owes us, oldest first.
  out_item_t  pending_duty [$];

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  bit          idling      = 1'b1;

  fan_pwm_ramp_controller #(.NUM_MOTORS(NUM_MOT)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Hard stop in case the block hangs a handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fan_pwm_ramp_controller_tb: FAIL");
      $finish;
    end
  end

  // Output back-pressure: random stall bursts while idling is enabled.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 19);
    end
    out_stall_i <= (stall_left != 0);
  end

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("MISMATCH @%0t: %s", $time, what);
    end
  endtask

  // Values sampled here are the pre-edge ones, so a transfer is exactly
  // valid high and stall low at this edge.
  always @(posedge clk_i) begin : check_duty
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_duty.size() == 0) begin
        report_mismatch($sformatf("unexpected update motor %0d duty %0d",
                                  out_o.motor_out, out_o.duty_pct));
      end else begin
        want = pending_duty.pop_front();
        if (out_o.motor_out !== want.motor_out) begin
          report_mismatch($sformatf("motor_out %0d, want %0d",
                                    out_o.motor_out, want.motor_out));
        end
        if (out_o.duty_pct !== want.duty_pct) begin
          report_mismatch($sformatf("duty_pct %0d, want %0d (motor %0d)",
                                    out_o.duty_pct, want.duty_pct, want.motor_out));
        end
      end
    end
  end

  function automatic void reset_model();
    fan_cfg.min_start_pct  = RST_MIN_START;
    fan_cfg.idle_pct       = RST_IDLE;
    fan_cfg.ramp_up_step   = RST_RAMP_UP;
    fan_cfg.ramp_down_step = RST_RAMP_DOWN;
    fan_cfg.spindown_ticks = RST_SPINDOWN;
    foreach (motor_st[k]) begin
      motor_st[k].mode       = MODE_SPINDOWN;
      motor_st[k].wait_count = RST_SPINDOWN;
      motor_st[k].goal_pct   = '0;
      motor_st[k].accum_q    = '0;
      motor_st[k].last_duty  = '0;
    end
  endfunction

  // Move the accumulator one step toward the goal, landing on it exactly;
  // report a new duty only when the whole percent changes.
  function automatic bit ramp_motor(int unsigned m, output out_item_t res);
    int unsigned target_q;
    int unsigned acc;
    int unsigned whole;
    res      = '0;
    target_q = int'(motor_st[m].goal_pct) << FRAC_W;
    acc      = motor_st[m].accum_q;
    if (acc == target_q) return 1'b0;
    if (acc < target_q) begin
      if (target_q - acc <= fan_cfg.ramp_up_step) acc = target_q;
      else acc += fan_cfg.ramp_up_step;
    end else begin
      if (acc - target_q <= fan_cfg.ramp_down_step) acc = target_q;
      else acc -= fan_cfg.ramp_down_step;
    end
    motor_st[m].accum_q = acc[ACC_W-1:0];
    whole = acc >> FRAC_W;
    if (whole == motor_st[m].last_duty) return 1'b0;
    motor_st[m].last_duty = whole[PCT_W-1:0];
    res.motor_out = m[SEL_W-1:0];
    res.duty_pct  = whole[PCT_W-1:0];
    return 1'b1;
  endfunction

  // Apply one accepted tick to the shadow state; returns 1 with the duty
  // update it should cause, if any.
  function automatic bit advance_motor(in_item_t it, output out_item_t res);
    int unsigned m;
    int unsigned req;
    int unsigned mstart;
    res    = '0;
    m      = it.motor_sel;
    req    = (it.request_pct > FULL_PCT) ? FULL_PCT : it.request_pct;
    mstart = (fan_cfg.min_start_pct > FULL_PCT) ? FULL_PCT : fan_cfg.min_start_pct;

    // Minimum-start kick: once it lands, take the request as the new goal.
    if (motor_st[m].mode == MODE_MINSTART) begin
      if (motor_st[m].accum_q == (int'(motor_st[m].goal_pct) << FRAC_W)) begin
        motor_st[m].goal_pct = req[PCT_W-1:0];
        motor_st[m].mode     = MODE_RAMPING;
        return 1'b0;
      end
      return ramp_motor(m, res);
    end

    // Spin-down: count down, then fall through and serve this tick.
    if (motor_st[m].mode != MODE_RAMPING) begin
      if (motor_st[m].wait_count != 0) motor_st[m].wait_count--;
      if (motor_st[m].wait_count != 0) return 1'b0;
      motor_st[m].mode = MODE_RAMPING;
    end

    // Turn-off drops straight to zero and restarts the spin-down wait.
    if (req == 0) begin
      if (motor_st[m].goal_pct == 0 && motor_st[m].accum_q == 0) return 1'b0;
      motor_st[m].wait_count = fan_cfg.spindown_ticks;
      motor_st[m].accum_q    = '0;
      motor_st[m].goal_pct   = '0;
      motor_st[m].last_duty  = '0;
      motor_st[m].mode       = MODE_SPINDOWN;
      res.motor_out = m[SEL_W-1:0];
      res.duty_pct  = '0;
      return 1'b1;
    end

    // A weak request on a motor below idle kicks it to the start level first.
    if (req < mstart && motor_st[m].goal_pct < fan_cfg.idle_pct) begin
      motor_st[m].goal_pct = mstart[PCT_W-1:0];
      motor_st[m].mode     = MODE_MINSTART;
      return ramp_motor(m, res);
    end

    motor_st[m].goal_pct = req[PCT_W-1:0];
    return ramp_motor(m, res);
  endfunction

  function automatic in_item_t tick_of(int unsigned m, int unsigned pct);
    in_item_t it;
    it.motor_sel   = m[SEL_W-1:0];
    it.request_pct = pct[PCT_W-1:0];
    return it;
  endfunction

  // Offer one tick and hold it until the transfer; called and left at a
  // rising edge. Stall is read at the falling edge, where it has settled.
  task automatic send_tick(in_item_t it);
    out_item_t res;
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= it;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    if (advance_motor(it, res)) pending_duty.push_back(res);
  endtask

  // Drop valid, wait out every owed update, then let the pipe go quiet.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (pending_duty.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Write all five registers; junk above each field's width must be
  // dropped, and a write to an unused index must change nothing.
  task automatic program_regs(cfg_t c);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_MIN_START, {junk[15:7], c.min_start_pct});
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_IDLE, {junk[15:7], c.idle_pct});
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_RAMP_UP, {junk[15], c.ramp_up_step});
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_RAMP_DOWN, {junk[15], c.ramp_down_step});
    write_reg(CFG_SPINDOWN, c.spindown_ticks);
    write_reg(CFG_UNUSED_FIRST + CFG_IDX_W'($urandom_range(0, 2)),
              CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
    fan_cfg = c;
  endtask

  function automatic cfg_t make_cfg(int unsigned mstart, int unsigned idle,
                                    int unsigned up, int unsigned down,
                                    int unsigned spin);
    cfg_t c;
    c.min_start_pct  = mstart[PCT_W-1:0];
    c.idle_pct       = idle[PCT_W-1:0];
    c.ramp_up_step   = up[STEP_W-1:0];
    c.ramp_down_step = down[STEP_W-1:0];
    c.spindown_ticks = spin[WAIT_W-1:0];
    return c;
  endfunction

  function automatic int unsigned pick_step();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return 1;
      2:       return FULL_Q;
      3:       return (1 << STEP_W) - 1;
      default: return $urandom_range(32, 3000);
    endcase
  endfunction

  function automatic cfg_t random_settings();
    int unsigned mstart;
    int unsigned idle;
    int unsigned spin;
    case ($urandom_range(0, 9))
      0:       mstart = 0;
      1:       mstart = $urandom_range(100, 127);
      default: mstart = $urandom_range(10, 60);
    endcase
    case ($urandom_range(0, 9))
      0:       idle = 0;
      1:       idle = $urandom_range(100, 127);
      default: idle = $urandom_range(5, 50);
    endcase
    spin = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    return make_cfg(mstart, idle, pick_step(), pick_step(), spin);
  endfunction

  // Mostly sensible targets, with turn-offs, weak starts and overrange values.
  function automatic int unsigned pick_request(int unsigned mstart);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return 0;
    if (r < 27 && mstart > 1) return $urandom_range(1, mstart - 1);
    if (r < 35) return $urandom_range(101, 127);
    return $urandom_range(1, 100);
  endfunction

  // Every motor leaves reset in spin-down with the default wait; tick each
  // one through it. Only the last tick per motor is acted on.
  task automatic test_wake();
    repeat (RST_SPINDOWN) begin
      for (int m = 0; m < NUM_MOT; m++) send_tick(tick_of(m, $urandom_range(0, 127)));
    end
    wait_quiet();
  endtask

  task automatic test_directed();
    // Big steps so each change lands in a tick or a few.
    program_regs(make_cfg(30, 20, FULL_Q, 6400, 0));
    send_tick(tick_of(0, 100));   // straight to full
    send_tick(tick_of(0, 127));   // overrange saturates, no change
    send_tick(tick_of(0, 40));    // ramp down in quarter steps
    send_tick(tick_of(0, 40));
    send_tick(tick_of(0, 40));
    send_tick(tick_of(0, 0));     // turn-off, zero spin-down
    send_tick(tick_of(0, 0));     // already off: nothing
    send_tick(tick_of(0, 10));    // weak request kicks to start level
    send_tick(tick_of(0, 10));    // kick done, take request as goal
    send_tick(tick_of(0, 10));
    send_tick(tick_of(1, 127));
    send_tick(tick_of(2, 1));
    send_tick(tick_of(3, 99));
    wait_quiet();
    // Saturated start level, highest idle threshold, frozen ramps.
    program_regs(make_cfg(127, 127, 0, 0, 0));
    send_tick(tick_of(1, 50));    // goal moves, accumulator cannot
    send_tick(tick_of(1, 0));     // turn-off still drops to zero
    send_tick(tick_of(1, 5));     // kicked, but stuck below the start level
    send_tick(tick_of(3, 1));
    wait_quiet();
    // No start level, no idle threshold, finest up step, widest down step.
    program_regs(make_cfg(0, 0, 1, (1 << STEP_W) - 1, 0));
    send_tick(tick_of(2, 1));
    send_tick(tick_of(2, 2));
    send_tick(tick_of(3, 0));
    send_tick(tick_of(3, 0));
    send_tick(tick_of(2, 0));
    wait_quiet();
  endtask

  // Long spin-down: turn a motor off and tick it all the way back.
  task automatic test_long_spindown();
    idling = 1'b0;
    program_regs(make_cfg(30, 20, FULL_Q, FULL_Q, LONG_SPIN));
    while (motor_st[3].mode != MODE_RAMPING) send_tick(tick_of(3, 50));
    send_tick(tick_of(3, 50));
    send_tick(tick_of(3, 0));
    repeat (LONG_SPIN - 2) send_tick(tick_of(3, $urandom_range(0, 127)));
    send_tick(tick_of(3, 70));
    wait_quiet();
    idling = 1'b1;
  endtask

  // Random settings per phase; targets stick per motor so ramps and kicks
  // run to completion, with some one-off noise mixed in.
  task automatic test_random_ramps();
    cfg_t        c;
    in_item_t    it;
    int unsigned aim [NUM_MOT];
    int unsigned mstart;
    int unsigned m;
    for (int ph = 0; ph < PHASES; ph++) begin
      c = random_settings();
      program_regs(c);
      // Quiet stretches now and then; none at all in the closing phases.
      idling = (ph < PHASES - 2) && ($urandom_range(0, 3) != 0);
      mstart = (c.min_start_pct > FULL_PCT) ? FULL_PCT : c.min_start_pct;
      foreach (aim[k]) aim[k] = pick_request(mstart);
      for (int n = 0; n < PHASE_TICKS; n++) begin
        m = $urandom_range(0, NUM_MOT - 1);
        if ($urandom_range(0, 7) == 0) aim[m] = pick_request(mstart);
        it = tick_of(m, aim[m]);
        if ($urandom_range(0, 19) == 0) it.request_pct = PCT_W'($urandom_range(0, 127));
        send_tick(it);
      end
      wait_quiet();
    end
  endtask

  initial begin
    reset_model();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_i        <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_wake();
    test_directed();
    test_long_spindown();
    test_random_ramps();

    wait_quiet();
    if (mismatches == 0) begin
      $display("fan_pwm_ramp_controller_tb: PASS");
    end else begin
      $display("fan_pwm_ramp_controller_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/fpr_pkg.sv
sv/fpr_step.sv
sv/fan_pwm_ramp_controller.sv
dv/fan_pwm_ramp_controller_tb.sv
